/* src/cpu_undocumented_word_alu_macros.svh */
// Assertion macros used by the word ALU top-level RTL file.
`ifndef CPU_UNDOCUMENTED_WORD_ALU_MACROS_SVH
`define CPU_UNDOCUMENTED_WORD_ALU_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define CUWA_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition holds at every clock edge out of reset.
`define CUWA_ASSERT_ALWAYS(lbl, cond, msg) \
  `CUWA_ASSERT_CLK(lbl, 1'b1 |-> (cond), msg)

`endif

/* src/cuwa_pkg.sv */
// Types, codes and flag positions for the undocumented word ALU.
package cuwa_pkg;

  typedef enum logic [2:0] {
    CMD_DSUB = 3'd0,
    CMD_ARHL = 3'd1,
    CMD_RDEL = 3'd2,
    CMD_INX  = 3'd3,
    CMD_DCX  = 3'd4
  } cuwa_cmd_e;

  localparam int unsigned FlagS = 7;
  localparam int unsigned FlagZ = 6;
  localparam int unsigned FlagK = 5;
  localparam int unsigned FlagA = 4;
  localparam int unsigned FlagX = 3;
  localparam int unsigned FlagP = 2;
  localparam int unsigned FlagV = 1;
  localparam int unsigned FlagC = 0;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] hl_value;
    logic [15:0] bc_value;
    logic [15:0] de_value;
    logic [15:0] step_word;
    logic [7:0]  flags_in;
  } cuwa_req_t;

  typedef struct packed {
    logic [15:0] word_out;
    logic [7:0]  flags_out;
  } cuwa_rsp_t;

endpackage

/* src/cuwa_in_stage.sv */
// Input register stage: captures one request per transfer.
module cuwa_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  cuwa_pkg::cuwa_req_t req_i,
  output logic               valid_o,
  input  logic               advance_i,
  output cuwa_pkg::cuwa_req_t req_o
);

  logic               valid_q, valid_d;
  cuwa_pkg::cuwa_req_t req_q;
  logic               load;

  assign stall_o = valid_q && !advance_i;
  assign load    = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

/* src/cuwa_exec.sv */
// Combinational execute logic for the five word operations.
module cuwa_exec (
  input  cuwa_pkg::cuwa_req_t req_i,
  output cuwa_pkg::cuwa_rsp_t rsp_o
);

  logic [16:0] diff;
  logic [11:0] neg_bc;
  logic [12:0] half_sum;
  logic [15:0] word;
  logic [7:0]  flags;

  assign diff     = {1'b0, req_i.hl_value} - {1'b0, req_i.bc_value};
  assign neg_bc   = 12'd0 - req_i.bc_value[11:0];
  assign half_sum = {1'b0, req_i.hl_value[11:0]} + {1'b0, neg_bc};

  always_comb begin
    word  = 16'd0;
    flags = req_i.flags_in;
    case (req_i.command)
      cuwa_pkg::CMD_DSUB: begin
        word                  = diff[15:0];
        flags[cuwa_pkg::FlagC] = diff[16];
        flags[cuwa_pkg::FlagS] = diff[15];
        flags[cuwa_pkg::FlagZ] = (diff[15:0] == 16'd0);
        flags[cuwa_pkg::FlagA] = half_sum[12];
        flags[cuwa_pkg::FlagP] = ~^diff[15:8];
      end
      cuwa_pkg::CMD_ARHL: begin
        word                  = {req_i.hl_value[15], req_i.hl_value[15:1]};
        flags[cuwa_pkg::FlagC] = req_i.hl_value[0];
      end
      cuwa_pkg::CMD_RDEL: begin
        word                  = {req_i.de_value[14:0], req_i.flags_in[cuwa_pkg::FlagC]};
        flags[cuwa_pkg::FlagC] = req_i.de_value[15];
        flags[cuwa_pkg::FlagV] = req_i.de_value[15] ^ req_i.de_value[14];
      end
      cuwa_pkg::CMD_INX: begin
        word                  = req_i.step_word + 16'd1;
        flags[cuwa_pkg::FlagK] = (req_i.step_word == 16'hffff);
      end
      cuwa_pkg::CMD_DCX: begin
        word                  = req_i.step_word - 16'd1;
        flags[cuwa_pkg::FlagK] = (req_i.step_word == 16'h0000);
      end
      default: begin
        word = 16'd0;
      end
    endcase
    flags[cuwa_pkg::FlagX] = 1'b0;
  end

  assign rsp_o.word_out  = word;
  assign rsp_o.flags_out = flags;

endmodule

/* src/cuwa_out_stage.sv */
// Result register stage: holds one response until the consumer takes it.
module cuwa_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               advance_o,
  input  cuwa_pkg::cuwa_rsp_t rsp_i,
  output logic               valid_o,
  input  logic               stall_i,
  output cuwa_pkg::cuwa_rsp_t rsp_o
);

  logic               valid_q, valid_d;
  cuwa_pkg::cuwa_rsp_t rsp_q;

  assign advance_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

/* src/cpu_undocumented_word_alu.sv */
// Top level of the undocumented word ALU: input register, execute, result register.
// An input transfer is captured in the input register, executed, then captured in the result register.
// Throughput: one transfer per cycle while the result is not stalled; only the execute cone lies between them.
// A stalled result holds the result register; the input register refills as soon as it moves.
// Reset clears both valid flags asynchronously; payload registers are not reset.
`include "cpu_undocumented_word_alu_macros.svh"

module cpu_undocumented_word_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] hl_value_i,
  input  logic [15:0] bc_value_i,
  input  logic [15:0] de_value_i,
  input  logic [15:0] step_word_i,
  input  logic [7:0]  flags_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] word_out_o,
  output logic [7:0]  flags_out_o
);

  cuwa_pkg::cuwa_req_t req_in, req_s1;
  cuwa_pkg::cuwa_rsp_t rsp_exec, rsp_out;
  logic                s1_valid;
  logic                advance;
  logic                out_held;

  assign req_in.command   = command_i;
  assign req_in.hl_value  = hl_value_i;
  assign req_in.bc_value  = bc_value_i;
  assign req_in.de_value  = de_value_i;
  assign req_in.step_word = step_word_i;
  assign req_in.flags_in  = flags_in_i;

  cuwa_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .req_i     (req_in),
    .valid_o   (s1_valid),
    .advance_i (advance),
    .req_o     (req_s1)
  );

  cuwa_exec u_exec (
    .req_i (req_s1),
    .rsp_o (rsp_exec)
  );

  cuwa_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .advance_o (advance),
    .rsp_i     (rsp_exec),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .rsp_o     (rsp_out)
  );

  assign word_out_o  = rsp_out.word_out;
  assign flags_out_o = rsp_out.flags_out;

  assign out_held = out_valid_o && out_stall_i;

  `CUWA_ASSERT_CLK(a_s1_moves_to_out, s1_valid && !out_held |=> out_valid_o, "item not forwarded")
  `CUWA_ASSERT_CLK(a_in_lands_in_s1, in_valid_i && !in_stall_o |=> s1_valid, "transfer lost")
  `CUWA_ASSERT_CLK(a_stall_only_when_full, in_stall_o |-> s1_valid && out_held, "bad stall")
  `CUWA_ASSERT_ALWAYS(a_flag_bit3_zero, !out_valid_o || !flags_out_o[cuwa_pkg::FlagX], "bit 3 set")

endmodule

/* tb/sv/cpu_undocumented_word_alu_tb.sv */
// Self-checking testbench for the undocumented word ALU: directed corners, then random traffic.
`timescale 1ns / 100ps

module cpu_undocumented_word_alu_tb;
  import cuwa_pkg::*;

  localparam logic [2:0] CmdNop5 = 3'd5;
  localparam logic [2:0] CmdNop6 = 3'd6;
  localparam logic [2:0] CmdNop7 = 3'd7;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned QuietTail = 1100;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned ReportLimit = 10;

  class word_alu_scoreboard;
    cuwa_rsp_t expected_q[$];
    int unsigned error_count;
    int unsigned results_checked;
    int unsigned cmd_count[8];

    function cuwa_rsp_t predict_alu(cuwa_req_t r);
      cuwa_rsp_t res;
      logic [15:0] w;
      logic [7:0] f;
      logic [11:0] neg_low;
      logic [12:0] half_sum;
      f = r.flags_in;
      w = '0;
      case (r.command)
        CMD_DSUB: begin
          w = r.hl_value - r.bc_value;
          neg_low = 12'd0 - r.bc_value[11:0];
          half_sum = {1'b0, r.hl_value[11:0]} + {1'b0, neg_low};
          f[FlagS] = w[15];
          f[FlagZ] = (w == 16'h0000);
          f[FlagA] = half_sum[12];
          f[FlagP] = ~^w[15:8];
          f[FlagC] = (r.hl_value < r.bc_value);
        end
        CMD_ARHL: begin
          f[FlagC] = r.hl_value[0];
          w = {r.hl_value[15], r.hl_value[15:1]};
        end
        CMD_RDEL: begin
          f[FlagC] = r.de_value[15];
          f[FlagV] = r.de_value[15] ^ r.de_value[14];
          w = {r.de_value[14:0], r.flags_in[FlagC]};
        end
        CMD_INX: begin
          f[FlagK] = (r.step_word == 16'hffff);
          w = r.step_word + 16'd1;
        end
        CMD_DCX: begin
          f[FlagK] = (r.step_word == 16'h0000);
          w = r.step_word - 16'd1;
        end
        default: w = '0;
      endcase
      f[FlagX] = 1'b0;
      res.word_out = w;
      res.flags_out = f;
      return res;
    endfunction

    function void note_transfer(cuwa_req_t r);
      cmd_count[r.command]++;
      expected_q.push_back(predict_alu(r));
    endfunction

    function void check_result(cuwa_rsp_t got);
      cuwa_rsp_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("%0t: result with nothing pending: word %h flags %h",
                   $time, got.word_out, got.flags_out);
        return;
      end
      want = expected_q.pop_front();
      if (got.word_out !== want.word_out || got.flags_out !== want.flags_out) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("%0t: mismatch: word exp %h got %h, flags exp %h got %h",
                   $time, want.word_out, got.word_out, want.flags_out, got.flags_out);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [15:0] hl_value_i = '0;
  logic [15:0] bc_value_i = '0;
  logic [15:0] de_value_i = '0;
  logic [15:0] step_word_i = '0;
  logic [7:0]  flags_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] word_out_o;
  logic [7:0]  flags_out_o;

  bit quiet_tail = 1'b0;
  int unsigned quiet_cycles = 0;
  word_alu_scoreboard sb = new();

  cpu_undocumented_word_alu i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .hl_value_i  (hl_value_i),
    .bc_value_i  (bc_value_i),
    .de_value_i  (de_value_i),
    .step_word_i (step_word_i),
    .flags_in_i  (flags_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_out_o  (word_out_o),
    .flags_out_o (flags_out_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic cuwa_req_t make_req(logic [2:0] cmd, logic [15:0] hl, logic [15:0] bc,
                                         logic [15:0] de, logic [15:0] sw, logic [7:0] fl);
    cuwa_req_t r;
    r.command = cmd;
    r.hl_value = hl;
    r.bc_value = bc;
    r.de_value = de;
    r.step_word = sw;
    r.flags_in = fl;
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      3: return $urandom_range(0, 1) ? 16'h0fff : 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  task automatic drive_transfer(input cuwa_req_t r);
    in_valid_i  <= 1'b1;
    command_i   <= r.command;
    hl_value_i  <= r.hl_value;
    bc_value_i  <= r.bc_value;
    de_value_i  <= r.de_value;
    step_word_i <= r.step_word;
    flags_in_i  <= r.flags_in;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(r);
  endtask

  task automatic idle_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // receiver backpressure
  initial begin
    forever begin
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{word_out: word_out_o, flags_out: flags_out_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cuwa_req_t directed_q[$];
    cuwa_req_t r;
    logic [2:0] cmd;
    logic [15:0] hl;
    logic [15:0] bc;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_q.push_back(make_req(CMD_DSUB, 16'h0000, 16'h0000, rnd16(), rnd16(), 8'h00));
    directed_q.push_back(make_req(CMD_DSUB, 16'h0000, 16'h0001, rnd16(), rnd16(), 8'hff));
    directed_q.push_back(make_req(CMD_DSUB, 16'hffff, 16'h0000, rnd16(), rnd16(), 8'hff));
    directed_q.push_back(make_req(CMD_DSUB, 16'h8000, 16'h0001, rnd16(), rnd16(), 8'h00));
    directed_q.push_back(make_req(CMD_DSUB, 16'h1000, 16'h0001, rnd16(), rnd16(), 8'h00));
    directed_q.push_back(make_req(CMD_DSUB, 16'h0fff, 16'h0fff, rnd16(), rnd16(), 8'hff));
    directed_q.push_back(make_req(CMD_DSUB, 16'h0000, 16'hffff, rnd16(), rnd16(), 8'h00));
    directed_q.push_back(make_req(CMD_ARHL, 16'h8001, rnd16(), rnd16(), rnd16(), 8'h00));
    directed_q.push_back(make_req(CMD_ARHL, 16'h0001, rnd16(), rnd16(), rnd16(), 8'hfe));
    directed_q.push_back(make_req(CMD_ARHL, 16'h7ffe, rnd16(), rnd16(), rnd16(), 8'hff));
    directed_q.push_back(make_req(CMD_RDEL, rnd16(), rnd16(), 16'h8000, rnd16(), 8'h01));
    directed_q.push_back(make_req(CMD_RDEL, rnd16(), rnd16(), 16'h4000, rnd16(), 8'h00));
    directed_q.push_back(make_req(CMD_RDEL, rnd16(), rnd16(), 16'hc000, rnd16(), 8'hfe));
    directed_q.push_back(make_req(CMD_RDEL, rnd16(), rnd16(), 16'hffff, rnd16(), 8'h00));
    directed_q.push_back(make_req(CMD_INX, rnd16(), rnd16(), rnd16(), 16'hffff, 8'h00));
    directed_q.push_back(make_req(CMD_INX, rnd16(), rnd16(), rnd16(), 16'h0000, 8'hff));
    directed_q.push_back(make_req(CMD_INX, rnd16(), rnd16(), rnd16(), 16'h7fff, 8'h00));
    directed_q.push_back(make_req(CMD_DCX, rnd16(), rnd16(), rnd16(), 16'h0000, 8'h00));
    directed_q.push_back(make_req(CMD_DCX, rnd16(), rnd16(), rnd16(), 16'h0001, 8'hff));
    directed_q.push_back(make_req(CMD_DCX, rnd16(), rnd16(), rnd16(), 16'hffff, 8'h00));
    directed_q.push_back(make_req(CmdNop5, rnd16(), rnd16(), rnd16(), rnd16(), 8'hff));
    directed_q.push_back(make_req(CmdNop6, rnd16(), rnd16(), rnd16(), rnd16(), 8'h08));
    directed_q.push_back(make_req(CmdNop7, rnd16(), rnd16(), rnd16(), rnd16(), 8'h00));

    foreach (directed_q[i]) begin
      drive_transfer(directed_q[i]);
      idle_gap();
    end

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i >= QuietTail) quiet_tail = 1'b1;
      if ($urandom_range(0, 9) == 0) cmd = 3'($urandom_range(CmdNop5, CmdNop7));
      else cmd = 3'($urandom_range(CMD_DSUB, CMD_DCX));
      hl = pick_word();
      bc = pick_word();
      // operands close together hit zero and the borrow boundary
      if (cmd == CMD_DSUB && $urandom_range(0, 3) == 0) bc = hl + 16'($urandom_range(0, 4)) - 16'd2;
      r = make_req(cmd, hl, bc, pick_word(), pick_word(), 8'($urandom));
      drive_transfer(r);
      idle_gap();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d transfers: dsub %0d, arhl %0d, rdel %0d, inx %0d, dcx %0d, unused %0d",
             directed_q.size() + RandomItems, sb.cmd_count[CMD_DSUB], sb.cmd_count[CMD_ARHL],
             sb.cmd_count[CMD_RDEL], sb.cmd_count[CMD_INX], sb.cmd_count[CMD_DCX],
             sb.cmd_count[CmdNop5] + sb.cmd_count[CmdNop6] + sb.cmd_count[CmdNop7]);
    $display("Checked %0d results under random gaps and backpressure, %0d mismatches",
             sb.results_checked, sb.error_count);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
